### rtl/keypad_click_autorepeat_unit_macros.svh
// ---------------------------------------------------------------------------
// Keypad click autorepeat unit - assertion macros
// Concurrent checks on the unit clock, disabled while reset is held.
// Synthesis builds see empty macros.
// ---------------------------------------------------------------------------
`ifndef KEYPAD_CLICK_AUTOREPEAT_UNIT_MACROS_SVH
`define KEYPAD_CLICK_AUTOREPEAT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every edge
`define KCA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define KCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KCA_ASSERT_ALWAYS(lbl, cond, msg)
`define KCA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/kca_pkg.sv
// ---------------------------------------------------------------------------
// Keypad click autorepeat package
// Key table, action codes, register indexes and reset defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package kca_pkg;

    // Default sizing
    localparam int KEY_GROUPS_DEF = 3;
    localparam int TICK_BITS_DEF  = 32;

    // Input word layout
    localparam int INPUT_GROUPS = 3;
    localparam int WORD_W       = 32;
    localparam int TIME_W       = 32;
    localparam int S_TDATA_W    = INPUT_GROUPS * WORD_W + TIME_W;
    localparam int S_TUSER_W    = 2;

    // Result word layout
    localparam int KEY_CODE_W   = 4;
    localparam int M_TDATA_W    = 8;

    // Configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 1'b1;
    localparam logic [CFG_DATA_W-1:0] FIRST_DELAY_RST  = 16'd500;
    localparam logic [CFG_DATA_W-1:0] REPEAT_DELAY_RST = 16'd175;

    // Action codes carried in tuser
    typedef enum logic [S_TUSER_W-1:0] {
        ACT_SCAN   = 2'd0,
        ACT_POLL   = 2'd1,
        ACT_FORGET = 2'd2
    } action_t;

    // Key table in priority order; key code is the 1-based position
    localparam int KEY_COUNT = 13;
    localparam logic [2:0] KEY_GROUP [KEY_COUNT] = '{
        3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
    };
    localparam logic [WORD_W-1:0] KEY_MASK [KEY_COUNT] = '{
        32'h0000_0001, 32'h0100_0000, 32'h0400_0000, 32'h1000_0000,
        32'h2000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0002,
        32'h0000_0004, 32'h0000_0008, 32'h0000_0030, 32'h0000_0020,
        32'h0000_0010
    };

endpackage

`default_nettype wire

### rtl/keypad_click_autorepeat_unit.sv
// ---------------------------------------------------------------------------
// Keypad click autorepeat unit
// Detects key clicks on active-low key matrix words and repeats a held key.
// ---------------------------------------------------------------------------
// The unit takes one word per clock and returns exactly one result word per
// input word, in order. A word is captured in the input register, then
// decoded in a single pass (thirteen-key priority logic plus one subtract
// and compare on the tick count) that updates the key state and loads the
// result register, from which the result drives m_tdata. Sustained rate
// is one word per cycle while results are taken, set by the one decode
// stage; the input side only stalls when both the input and the result
// register hold words and the result is not being taken. Scan (tuser 0)
// loads new key words, poll (tuser 1) returns a click or autorepeat key
// code, forget (tuser 2) drops the held key; scan, forget and the unused
// code return key code 0.
`default_nettype none

`include "keypad_click_autorepeat_unit_macros.svh"

module keypad_click_autorepeat_unit #(
    parameter int KEY_GROUPS = kca_pkg::KEY_GROUPS_DEF,
    parameter int TICK_BITS  = kca_pkg::TICK_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // raw_group0 [31:0], raw_group1 [63:32], raw_group2 [95:64],
    // current_time [127:96]
    input  wire logic [kca_pkg::S_TDATA_W-1:0]    s_tdata,
    // action [1:0]
    input  wire logic [kca_pkg::S_TUSER_W-1:0]    s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // key_code [3:0], zero fill [7:4]
    output logic [kca_pkg::M_TDATA_W-1:0]         m_tdata,
    // Configuration writes
    input  wire logic                             cfg_wr_en,
    input  wire logic [kca_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [kca_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int KC = kca_pkg::KEY_COUNT;
    localparam int WW = kca_pkg::WORD_W;
    localparam int CW = kca_pkg::KEY_CODE_W;

    // Handshake control
    logic advance;
    logic process;

    // Input register
    logic                              in_valid_reg;
    logic [kca_pkg::S_TUSER_W-1:0]     in_action_reg;
    logic [WW-1:0]                     in_raw_reg [kca_pkg::INPUT_GROUPS];
    logic [kca_pkg::TIME_W-1:0]        in_time_reg;

    // Result register
    logic                              out_valid_reg;
    logic [CW-1:0]                     out_code_reg;
    logic [CW-1:0]                     code_next;

    // Configuration registers
    logic [kca_pkg::CFG_DATA_W-1:0]    first_delay_reg;
    logic [kca_pkg::CFG_DATA_W-1:0]    repeat_delay_reg;

    // Key state
    logic [WW-1:0]                     cur_reg  [KEY_GROUPS];
    logic [WW-1:0]                     cur_next [KEY_GROUPS];
    logic [WW-1:0]                     prev_reg  [KEY_GROUPS];
    logic [WW-1:0]                     prev_next [KEY_GROUPS];
    logic [WW-1:0]                     scan_word [KEY_GROUPS];
    logic [CW-1:0]                     held_reg;
    logic [CW-1:0]                     held_next;
    logic [TICK_BITS-1:0]              last_emit_reg;
    logic [TICK_BITS-1:0]              last_emit_next;
    logic                              repeating_reg;
    logic                              repeating_next;

    // Decode signals
    logic [KC-1:0]                     key_pressed;
    logic [KC-1:0]                     key_rise;
    logic [CW-1:0]                     click;
    logic                              held_down;
    logic [TICK_BITS-1:0]              now;
    logic [TICK_BITS-1:0]              diff;
    logic [TICK_BITS-1:0]              limit;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(kca_pkg::M_TDATA_W - CW){1'b0}}, out_code_reg};

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            for (int g = 0; g < kca_pkg::INPUT_GROUPS; g++)
            begin
                in_raw_reg[g] <= s_tdata[g*WW +: WW];
            end
            in_time_reg <= s_tdata[kca_pkg::INPUT_GROUPS*WW +: kca_pkg::TIME_W];
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg  <= kca_pkg::FIRST_DELAY_RST;
            repeat_delay_reg <= kca_pkg::REPEAT_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                kca_pkg::CFG_FIRST_DELAY:  first_delay_reg  <= cfg_wdata;
                kca_pkg::CFG_REPEAT_DELAY: repeat_delay_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Words loaded on scan; groups without an input stay released
    for (genvar g = 0; g < KEY_GROUPS; g++)
    begin : g_scan
        if (g < kca_pkg::INPUT_GROUPS)
        begin : g_in
            assign scan_word[g] = in_raw_reg[g];
        end
        else
        begin : g_idle
            assign scan_word[g] = '1;
        end
    end

    // Per-key pressed and click detection
    for (genvar k = 0; k < KC; k++)
    begin : g_key
        localparam int GRP = int'(kca_pkg::KEY_GROUP[k]);
        if (GRP < KEY_GROUPS)
        begin : g_used
            assign key_pressed[k] = (cur_reg[GRP] & kca_pkg::KEY_MASK[k]) == '0;
            assign key_rise[k] = key_pressed[k] &&
                                 ((prev_reg[GRP] & kca_pkg::KEY_MASK[k]) != '0);
        end
        else
        begin : g_absent
            assign key_pressed[k] = 1'b0;
            assign key_rise[k] = 1'b0;
        end
    end

    // Pick the first click in table order and look up the held key
    always_comb
    begin
        click     = '0;
        held_down = 1'b0;
        for (int k = KC - 1; k >= 0; k--)
        begin
            if (key_rise[k])
            begin
                click = CW'(k + 1);
            end
        end
        for (int k = 0; k < KC; k++)
        begin
            if (held_reg == CW'(k + 1))
            begin
                held_down = key_pressed[k];
            end
        end
    end

    // Elapsed ticks since the last report, wrapped
    assign now   = TICK_BITS'(in_time_reg);
    assign diff  = now - last_emit_reg;
    assign limit = repeating_reg ? TICK_BITS'(repeat_delay_reg)
                                 : TICK_BITS'(first_delay_reg);

    // Work out the next key state and the result
    always_comb
    begin
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        held_next      = held_reg;
        last_emit_next = last_emit_reg;
        repeating_next = repeating_reg;
        code_next      = '0;
        case (in_action_reg)
            kca_pkg::ACT_SCAN:
            begin
                prev_next = cur_reg;
                cur_next  = scan_word;
            end
            kca_pkg::ACT_POLL:
            begin
                if (click != '0)
                begin
                    held_next      = click;
                    repeating_next = 1'b0;
                    last_emit_next = now;
                    code_next      = click;
                end
                else if (held_reg != '0 && held_down)
                begin
                    if (diff > limit)
                    begin
                        repeating_next = 1'b1;
                        last_emit_next = now;
                        code_next      = held_reg;
                    end
                end
                else
                begin
                    held_next = '0;
                end
            end
            kca_pkg::ACT_FORGET:
            begin
                held_next = '0;
            end
            default: ;
        endcase
    end

    // Advance key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < KEY_GROUPS; g++)
            begin
                cur_reg[g]  <= '1;
                prev_reg[g] <= '1;
            end
            held_reg      <= '0;
            last_emit_reg <= '0;
            repeating_reg <= 1'b0;
        end
        else if (process)
        begin
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            held_reg      <= held_next;
            last_emit_reg <= last_emit_next;
            repeating_reg <= repeating_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_code_reg <= code_next;
        end
    end

    // Held key is always a table code or none
    `KCA_ASSERT_ALWAYS(a_held_in_table, held_reg <= CW'(KC), "held key outside key table")
    // Only a poll can report a key
    `KCA_ASSERT_NEXT(a_code_from_poll, process && in_action_reg != kca_pkg::ACT_POLL, out_code_reg == '0, "nonzero key code from non-poll word")
    // A reported key becomes the held key
    `KCA_ASSERT_NEXT(a_report_holds, process && code_next != '0, held_reg == out_code_reg && last_emit_reg == $past(now), "reported key not held")

endmodule

`default_nettype wire
